### rtl/tcfd_pkg.sv
`default_nettype none
package tcfd_pkg;
	localparam int BATCH_SIZE_DEF = 10;
	localparam int LVL_W = 15;
	localparam int GUARD_JUMP = 60;
	localparam int LOW_SUM = 50;
	localparam logic KIND_MEASURE = 1'b0;
	localparam logic KIND_CAL = 1'b1;

	typedef struct packed {
		logic       kind;
		logic       running;
		logic [7:0] m_l;
		logic [7:0] m_r;
		logic [7:0] m_m;
	} batch_t;

	typedef struct packed {
		logic signed [7:0] deviation_out;
		logic [14:0]       left_level;
		logic [14:0]       right_level;
		logic [14:0]       middle_level;
		logic              low_signal;
	} result_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] left_sample;
		logic [7:0] right_sample;
		logic [7:0] middle_sample;
		logic       running;
	} sample_t;

	typedef enum logic [3:0] {
		B_IDLE, B_NORM, B_NDIV, B_GUARD, B_ROOT, B_SQR, B_QDIV, B_TRY, B_CMP,
		B_FILT, B_FDIV, B_CLAMP, B_OUT
	} back_state_t;
endpackage
`default_nettype wire

### rtl/tcfd_if.sv
`default_nettype none
interface tcfd_in_if;
	logic valid;
	logic ready;
	tcfd_pkg::sample_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tcfd_out_if;
	logic valid;
	logic ready;
	tcfd_pkg::result_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/tcfd_front.sv
`default_nettype none
module tcfd_front #(
	parameter int BATCH_SIZE = tcfd_pkg::BATCH_SIZE_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	tcfd_in_if.sink             in_ch,
	output tcfd_pkg::batch_t    batch,
	output logic                batch_valid,
	input  wire logic           batch_ready
);
	import tcfd_pkg::*;
	localparam int CW = $clog2(BATCH_SIZE + 1);
	localparam int IW = $clog2(BATCH_SIZE);
	localparam int MID = BATCH_SIZE / 2;

	logic [7:0] store_q [3][BATCH_SIZE];
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] pass_q;
	logic sorting_q, avg_q, kind_q, run_q;
	logic [9:0] sum_q [3];
	logic [1:0] ai_q;
	logic [7:0] mean_q [3];
	logic out_v_q;

	assign in_ch.ready = !sorting_q && !avg_q && !out_v_q;
	assign batch_valid = out_v_q;
	assign batch = '{kind: kind_q, running: run_q, m_l: mean_q[0], m_r: mean_q[1],
		m_m: mean_q[2]};

	// odd-even transposition sort: one compare-swap rank per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sorting_q <= 1'b0;
			avg_q <= 1'b0;
			out_v_q <= 1'b0;
			pass_q <= '0;
			ai_q <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				store_q[0][cnt_q[IW-1:0]] <= in_ch.payload.left_sample;
				store_q[1][cnt_q[IW-1:0]] <= in_ch.payload.right_sample;
				store_q[2][cnt_q[IW-1:0]] <= in_ch.payload.middle_sample;
				kind_q <= in_ch.payload.kind;
				run_q <= in_ch.payload.running;
				if (cnt_q == CW'(BATCH_SIZE - 1)) begin
					cnt_q <= '0;
					sorting_q <= 1'b1;
					pass_q <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (sorting_q) begin
				for (int c = 0; c < 3; c++)
					for (int i = 0; i + 1 < BATCH_SIZE; i++)
						if ((i & 1) == int'(pass_q[0]) &&
							store_q[c][i] > store_q[c][i+1]) begin
							store_q[c][i] <= store_q[c][i+1];
							store_q[c][i+1] <= store_q[c][i];
						end
				if (pass_q == IW'(BATCH_SIZE - 1)) begin
					sorting_q <= 1'b0;
					avg_q <= 1'b1;
					ai_q <= '0;
				end else begin
					pass_q <= pass_q + 1'b1;
				end
			end
			if (avg_q) begin
				if (ai_q == 2'd0) begin
					for (int c = 0; c < 3; c++)
						sum_q[c] <= 10'(store_q[c][MID-1]) + 10'(store_q[c][MID])
							+ 10'(store_q[c][MID+1]);
					ai_q <= 2'd1;
				end else begin
					for (int c = 0; c < 3; c++)
						mean_q[c] <= 8'((20'(sum_q[c]) * 20'd683) >> 11);
					avg_q <= 1'b0;
					out_v_q <= 1'b1;
				end
			end
			if (out_v_q && batch_ready)
				out_v_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

### rtl/tcfd_back.sv
`default_nettype none
module tcfd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              bias_we,
	input  wire logic signed [7:0] bias_wdata,
	input  wire tcfd_pkg::batch_t  batch,
	input  wire logic              batch_valid,
	output logic                   batch_ready,
	tcfd_out_if.source             out_ch
);
	import tcfd_pkg::*;

	back_state_t st_q, st_d;
	logic signed [7:0] bias_q;
	logic [7:0] mn_q [3];
	logic [7:0] mx_q [3];
	logic [14:0] prev_q [3];
	logic [14:0] lev_q [3];
	logic signed [7:0] pdev_q;
	logic guard_q;
	batch_t b_q;
	logic [1:0] ch_q;
	logic [14:0] num_q;
	logic [7:0] den_q;
	logic [14:0] quo_q;
	logic [3:0] bit_q;
	logic [16:0] sum_q;
	logic [16:0] s1;
	logic [16:0] a_q;
	logic neg_q;
	logic [9:0] n_q;
	logic [24:0] sa_q;
	logic [49:0] dsq_q;
	logic [17:0] rem_q;
	logic [5:0] dcnt_q;
	logic [27:0] u_q;
	logic signed [12:0] fnum_q;
	logic [8:0] fq_q;
	result_t res_q;
	logic ov_q;

	logic [7:0] mch, mnc, mxc;
	always_comb begin
		unique case (ch_q)
			2'd0: mch = b_q.m_l;
			2'd1: mch = b_q.m_r;
			default: mch = b_q.m_m;
		endcase
		mnc = mn_q[ch_q];
		mxc = mx_q[ch_q];
	end

	assign s1 = sum_q + 17'd1;
	assign batch_ready = (st_q == B_IDLE);
	assign out_ch.valid = ov_q;
	assign out_ch.payload = res_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			B_IDLE: if (batch_valid && batch.kind == KIND_MEASURE) st_d = B_NORM;
			B_NORM: begin
				if (mnc < mch && mxc > mnc) st_d = B_NDIV;
				else if (ch_q == 2'd2) st_d = B_GUARD;
			end
			B_NDIV: begin
				if (bit_q == 4'd0) st_d = (ch_q == 2'd2) ? B_GUARD : B_NORM;
			end
			B_GUARD: st_d = B_ROOT;
			B_ROOT: st_d = B_SQR;
			B_SQR: st_d = B_QDIV;
			B_QDIV: if (dcnt_q == 6'd0) st_d = B_TRY;
			B_TRY: st_d = B_CMP;
			B_CMP: st_d = (bit_q == 4'd0) ? B_FILT : B_TRY;
			B_FILT: st_d = B_FDIV;
			B_FDIV: st_d = B_CLAMP;
			B_CLAMP: st_d = B_OUT;
			B_OUT: if (!ov_q) st_d = B_IDLE;
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= B_IDLE;
		else st_q <= st_d;
	end

	logic [10:0] cand;
	assign cand = {1'b0, n_q} | (11'd1 << bit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			guard_q <= 1'b0;
			pdev_q <= '0;
			ov_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				mn_q[c] <= 8'd255;
				mx_q[c] <= 8'd0;
				prev_q[c] <= '0;
			end
		end else begin
			if (bias_we) bias_q <= bias_wdata;
			if (out_ch.valid && out_ch.ready) ov_q <= 1'b0;
			unique case (st_q)
				B_IDLE: if (batch_valid) begin
					b_q <= batch;
					ch_q <= '0;
					if (batch.kind == KIND_CAL) begin
						if (mx_q[0] < batch.m_l) mx_q[0] <= batch.m_l;
						if (mn_q[0] > batch.m_l) mn_q[0] <= batch.m_l;
						if (mx_q[1] < batch.m_r) mx_q[1] <= batch.m_r;
						if (mn_q[1] > batch.m_r) mn_q[1] <= batch.m_r;
						if (mx_q[2] < batch.m_m) mx_q[2] <= batch.m_m;
						if (mn_q[2] > batch.m_m) mn_q[2] <= batch.m_m;
					end
				end
				B_NORM: begin
					if (mnc >= mch) begin
						lev_q[ch_q] <= 15'd1;
					end else if (mxc <= mnc) begin
						lev_q[ch_q] <= 15'd100 * 15'(mch - mnc);
					end else begin
						num_q <= 15'd100 * 15'(mch - mnc);
						den_q <= mxc - mnc;
						quo_q <= '0;
						bit_q <= 4'd14;
					end
					if ((mnc >= mch || mxc <= mnc) && ch_q != 2'd2) ch_q <= ch_q + 1'b1;
				end
				B_NDIV: begin
					if ((num_q >> bit_q) >= 15'(den_q)) begin
						num_q <= num_q - (15'(den_q) << bit_q);
						quo_q[bit_q] <= 1'b1;
					end
					if (bit_q == 4'd0) begin
						lev_q[ch_q] <= ((num_q >> bit_q) >= 15'(den_q)) ?
							(quo_q | 15'd1) : quo_q;
						if (ch_q != 2'd2) ch_q <= ch_q + 1'b1;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				B_GUARD: begin
					logic g;
					logic [14:0] l [3];
					g = guard_q | b_q.running;
					guard_q <= g;
					for (int c = 0; c < 3; c++) begin
						l[c] = lev_q[c];
						if (g && ((prev_q[c] >= lev_q[c]) ?
							(prev_q[c] - lev_q[c]) : (lev_q[c] - prev_q[c])) >=
							15'(GUARD_JUMP))
							l[c] = prev_q[c];
						lev_q[c] <= l[c];
					end
					sum_q <= 17'(l[0]) + 17'(l[1]) + 17'(l[2]);
					neg_q <= l[1] < l[0];
					a_q <= 17'((l[1] >= l[0]) ? (l[1] - l[0]) : (l[0] - l[1]));
					n_q <= '0;
					bit_q <= 4'd9;
				end
				B_ROOT: sa_q <= 25'(a_q) * 25'd1000;
				B_SQR: begin
					dsq_q <= 50'(sa_q) * 50'(sa_q);
					rem_q <= '0;
					dcnt_q <= 6'd49;
				end
				// shift (1000*a)^2 through a restoring divide by s+1, quotient fills dsq_q
				B_QDIV: begin
					logic [17:0] r2;
					r2 = {rem_q[16:0], dsq_q[49]};
					if (r2 >= 18'(s1)) begin
						rem_q <= r2 - 18'(s1);
						dsq_q <= {dsq_q[48:0], 1'b1};
					end else begin
						rem_q <= r2;
						dsq_q <= {dsq_q[48:0], 1'b0};
					end
					dcnt_q <= dcnt_q - 1'b1;
				end
				B_TRY: u_q <= 28'(cand) * 28'(s1);
				B_CMP: begin
					if (56'(u_q) * 56'(u_q) <= 56'(dsq_q))
						n_q <= cand[9:0];
					if (bit_q != 4'd0) bit_q <= bit_q - 1'b1;
				end
				B_FILT: begin
					logic signed [12:0] dv;
					dv = (neg_q ? -13'(n_q) : 13'(n_q)) + 13'(bias_q);
					fnum_q <= 13'(pdev_q) * 13'sd2 + dv * 13'sd8;
				end
				B_FDIV: begin
					logic [12:0] mag;
					mag = fnum_q[12] ? 13'(-fnum_q) : 13'(fnum_q);
					fq_q <= 9'((26'(mag) * 26'd6554) >> 16);
				end
				B_CLAMP: begin
					logic signed [12:0] f;
					f = fnum_q[12] ? -13'(fq_q) : 13'(fq_q);
					if (f > 13'sd100) f = 13'sd100;
					if (f < -13'sd100) f = -13'sd100;
					pdev_q <= 8'(f);
					for (int c = 0; c < 3; c++) prev_q[c] <= lev_q[c];
					res_q <= '{deviation_out: 8'(f), left_level: lev_q[0],
						right_level: lev_q[1], middle_level: lev_q[2],
						low_signal: sum_q < 17'(LOW_SUM)};
					ov_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/three_coil_field_deviation.sv
`default_nettype none
// channel   dir  payload
// in_ch     in   kind, left/right/middle_sample, running
// out_ch    out  deviation_out, left/right/middle_level, low_signal
// bias      cfg  deviation_bias (write enable + data)
// One word is taken per sample; a batch then sorts in BATCH_SIZE passes
// (one transposition rank per cycle) and averages its middle three values.
// The back part takes a calibration batch straight from idle. A measure batch
// runs a level divide for each level that needs one, a 50-bit divide of
// (1000*a)^2 by the level sum plus one, and a ten-bit root search.
// Reset clears limits, history and guard. Input stalls while a batch sorts,
// averages or waits for the back part; the back part stalls on out_ch.ready.
module three_coil_field_deviation #(
	parameter int BATCH_SIZE = tcfd_pkg::BATCH_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        bias_we,
	input  wire logic [7:0]  bias_wdata,
	tcfd_in_if.sink          in_ch,
	tcfd_out_if.source       out_ch
);
	import tcfd_pkg::*;
	batch_t batch;
	logic batch_valid, batch_ready;

	tcfd_front #(.BATCH_SIZE(BATCH_SIZE)) u_front (
		.clk, .arst_n, .in_ch, .batch, .batch_valid, .batch_ready
	);
	tcfd_back u_back (
		.clk, .arst_n, .bias_we, .bias_wdata(signed'(bias_wdata)), .batch,
		.batch_valid, .batch_ready, .out_ch
	);
endmodule
`default_nettype wire

### sim/tcfd_tb_if.sv
`timescale 1ns / 1ps
interface tcfd_tb_cfg_if;
	logic       we;
	logic [7:0] wdata;
endinterface

### sim/tcfd_checker.sv
`timescale 1ns / 1ps
module tcfd_checker #(
	parameter int BATCH_SIZE = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              bias_we,
	input  logic [7:0]        bias_wdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  tcfd_pkg::sample_t in_word,
	input  logic              out_valid,
	input  logic              out_ready,
	input  tcfd_pkg::result_t out_word,
	output int                fail_count,
	output int                pending,
	output int                seen_count
);
	import tcfd_pkg::*;

	logic [7:0]        batch_l [BATCH_SIZE];
	logic [7:0]        batch_r [BATCH_SIZE];
	logic [7:0]        batch_m [BATCH_SIZE];
	int                fill;
	logic [7:0]        lo [3];
	logic [7:0]        hi [3];
	int                last_lvl [3];
	int                last_dev;
	logic              guard;
	int                bias;
	result_t           expected_q [$];

	function automatic int mid_mean(input logic [7:0] s [BATCH_SIZE]);
		int v [BATCH_SIZE];
		int t;
		for (int i = 0; i < BATCH_SIZE; i++) v[i] = s[i];
		for (int i = 0; i < BATCH_SIZE; i++)
			for (int j = 0; j < BATCH_SIZE - 1 - i; j++)
				if (v[j] > v[j + 1]) begin
					t = v[j]; v[j] = v[j + 1]; v[j + 1] = t;
				end
		return (v[BATCH_SIZE / 2 - 1] + v[BATCH_SIZE / 2] + v[BATCH_SIZE / 2 + 1]) / 3;
	endfunction

	function automatic longint root_quot(input longint a, input longint s);
		longint lim, n, c;
		lim = a * a / s;
		n = 0;
		for (int b = 9; b >= 0; b--) begin
			c = n | (64'd1 << b);
			if (c * c * s * s <= lim) n = c;
		end
		return n;
	endfunction

	task automatic absorb_sample(input sample_t w);
		int mn [3];
		int lv [3];
		int sum, d, dev, filt, diff;
		result_t r;
		batch_l[fill] = w.left_sample;
		batch_r[fill] = w.right_sample;
		batch_m[fill] = w.middle_sample;
		fill++;
		if (fill < BATCH_SIZE) return;
		fill = 0;
		mn[0] = mid_mean(batch_l);
		mn[1] = mid_mean(batch_r);
		mn[2] = mid_mean(batch_m);
		if (w.kind == KIND_CAL) begin
			for (int c = 0; c < 3; c++) begin
				if (hi[c] < mn[c]) hi[c] = mn[c];
				if (lo[c] > mn[c]) lo[c] = mn[c];
			end
			return;
		end
		for (int c = 0; c < 3; c++)
			if (lo[c] >= mn[c]) lv[c] = 1;
			else lv[c] = 100 * (mn[c] - lo[c]) / ((hi[c] > lo[c]) ? hi[c] - lo[c] : 1);
		if (w.running) guard = 1'b1;
		if (guard)
			for (int c = 0; c < 3; c++) begin
				diff = last_lvl[c] - lv[c];
				if (diff < 0) diff = -diff;
				if (diff >= GUARD_JUMP) lv[c] = last_lvl[c];
			end
		sum = lv[0] + lv[1] + lv[2];
		d = lv[1] - lv[0];
		dev = int'(root_quot(1000 * (d < 0 ? -d : d), sum + 1));
		if (d < 0) dev = -dev;
		dev += bias;
		filt = (last_dev * 2 + dev * 8) / 10;
		if (filt > 100) filt = 100;
		if (filt < -100) filt = -100;
		last_dev = filt;
		for (int c = 0; c < 3; c++) last_lvl[c] = lv[c];
		r.deviation_out = filt[7:0];
		r.left_level = lv[0][14:0];
		r.right_level = lv[1][14:0];
		r.middle_level = lv[2][14:0];
		r.low_signal = sum < LOW_SUM;
		expected_q.push_back(r);
	endtask

	task automatic compare_word(input result_t a);
		result_t e;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected word %p", $time, a);
			fail_count++;
			return;
		end
		e = expected_q.pop_front();
		if (a.deviation_out !== e.deviation_out || a.left_level !== e.left_level ||
			a.right_level !== e.right_level || a.middle_level !== e.middle_level ||
			a.low_signal !== e.low_signal) begin
			$display("%0t: mismatch expected %p actual %p", $time, e, a);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			guard = 1'b0;
			last_dev = 0;
			bias = 0;
			fail_count = 0;
			seen_count = 0;
			for (int c = 0; c < 3; c++) begin
				lo[c] = 8'd255; hi[c] = 8'd0; last_lvl[c] = 0;
			end
			expected_q.delete();
		end else begin
			if (bias_we) bias = $signed(bias_wdata);
			if (out_valid && out_ready) begin
				compare_word(out_word);
				seen_count++;
			end
			if (in_valid && in_ready) absorb_sample(in_word);
		end
		pending = expected_q.size();
	end
endmodule

### sim/three_coil_field_deviation_tb.sv
`timescale 1ns / 1ps
module three_coil_field_deviation_tb;
	import tcfd_pkg::*;

	localparam int BS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic quiet = 1'b0;
	int   fail_count, pending, seen_count;
	int   sent = 0;

	tcfd_in_if     in_ch ();
	tcfd_out_if    out_ch ();
	tcfd_tb_cfg_if cfg ();

	three_coil_field_deviation #(.BATCH_SIZE(BS)) dut (
		.clk(clk), .arst_n(arst_n), .bias_we(cfg.we), .bias_wdata(cfg.wdata),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	tcfd_checker #(.BATCH_SIZE(BS)) u_checker (
		.clk(clk), .arst_n(arst_n), .bias_we(cfg.we), .bias_wdata(cfg.wdata),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_word(in_ch.payload),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_word(out_ch.payload),
		.fail_count(fail_count), .pending(pending), .seen_count(seen_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int burst;
		out_ch.ready <= 1'b0;
		@(negedge clk);
		while (1) begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 18);
				out_ch.ready <= 1'b0;
				repeat (burst) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			@(negedge clk);
		end
	end

	task automatic send_word(input sample_t w);
		in_ch.valid <= 1'b1;
		in_ch.payload <= w;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
	endtask

	task automatic send_batch(input logic kind, input logic run, input int mode,
		input int base);
		sample_t w;
		for (int i = 0; i < BS; i++) begin
			w.kind = (i == BS - 1) ? kind : logic'($urandom_range(0, 1));
			w.running = (i == BS - 1) ? run : logic'($urandom_range(0, 1));
			case (mode)
				0: begin
					w.left_sample = $urandom; w.right_sample = $urandom;
					w.middle_sample = $urandom;
				end
				1: begin
					w.left_sample = base; w.right_sample = base; w.middle_sample = base;
				end
				default: begin
					w.left_sample = base + $urandom_range(0, 30);
					w.right_sample = 255 - base - $urandom_range(0, 30);
					w.middle_sample = base + $urandom_range(0, 60);
				end
			endcase
			send_word(w);
		end
	endtask

	task automatic drain_and_set(input logic [7:0] b);
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		cfg.we <= 1'b1;
		cfg.wdata <= b;
		@(negedge clk);
		cfg.we <= 1'b0;
	endtask

	initial begin
		int timeout;
		in_ch.valid <= 1'b0;
		in_ch.payload <= '0;
		cfg.we <= 1'b0;
		cfg.wdata <= 8'd0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_batch(KIND_MEASURE, 1'b0, 1, 0);
		send_batch(KIND_CAL, 1'b0, 1, 0);
		send_batch(KIND_MEASURE, 1'b0, 1, 0);
		send_batch(KIND_MEASURE, 1'b0, 1, 255);
		send_batch(KIND_CAL, 1'b0, 1, 255);
		drain_and_set(8'sd100);
		send_batch(KIND_MEASURE, 1'b0, 1, 128);
		send_batch(KIND_MEASURE, 1'b1, 1, 0);
		send_batch(KIND_MEASURE, 1'b0, 1, 255);
		drain_and_set(-8'sd100);
		send_batch(KIND_MEASURE, 1'b0, 0, 0);

		for (int p = 0; p < 4; p++) begin
			drain_and_set($urandom_range(0, 200) - 100);
			arst_n <= 1'b1;
			for (int k = 0; k < 25; k++)
				if ($urandom_range(0, 4) == 0)
					send_batch(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
						0, 0);
				else
					send_batch(logic'($urandom_range(0, 5) == 0),
						logic'($urandom_range(0, 7) == 0), $urandom_range(1, 2),
						$urandom_range(0, 200));
			if (p == 2) quiet = 1'b1;
		end
		in_ch.valid <= 1'b0;

		timeout = 0;
		while (pending != 0 && timeout < 100000) begin
			@(negedge clk);
			timeout++;
		end
		repeat (200) @(negedge clk);
		$display("Covered %0d samples, %0d results, bias swept over both extremes.",
			sent, seen_count);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
